[rtl/ewtd_pkg.sv]
`default_nettype none

package ewtd_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] MODE_Q = 2'd0;
    localparam logic [1:0] MODE_B = 2'd1;

    localparam logic [6:0] CHAR_EQ    = 7'h3d;
    localparam logic [6:0] CHAR_UNDER = 7'h5f;
    localparam logic [6:0] CHAR_SPACE = 7'h20;
    localparam logic [6:0] CHAR_PLUS  = 7'h2b;
    localparam logic [6:0] CHAR_SLASH = 7'h2f;

    typedef enum logic [1:0] {
        ESC_IDLE = 2'd0,
        ESC_EQ   = 2'd1,
        ESC_HEX  = 2'd2
    } t_esc_phase;

    typedef struct packed {
        logic [6:0] text_char;
        logic       final_char;
    } t_in_word;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_text;
        logic       decode_error;
    } t_out_word;

    // one decoded character's worth of results
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      n_bytes;
        logic            fin;
        logic            err;
    } t_job;

    // {bad, value}
    function automatic logic [4:0] hex_decode(input logic [6:0] c);
        logic [4:0] r;
        r = 5'h10;
        if (c >= 7'h30 && c <= 7'h39) r = {1'b0, 4'(c - 7'h30)};
        if (c >= 7'h41 && c <= 7'h46) r = {1'b0, 4'(c - 7'h37)};
        if (c >= 7'h61 && c <= 7'h66) r = {1'b0, 4'(c - 7'h57)};
        return r;
    endfunction

    // {bad, value}
    function automatic logic [6:0] sextet_decode(input logic [6:0] c);
        logic [6:0] r;
        r = 7'h40;
        if (c >= 7'h41 && c <= 7'h5a) r = {1'b0, 6'(c - 7'h41)};
        if (c >= 7'h61 && c <= 7'h7a) r = {1'b0, 6'(c - 7'h47)};
        if (c >= 7'h30 && c <= 7'h39) r = {1'b0, 6'(c + 7'h04)};
        if (c == CHAR_PLUS)  r = {1'b0, 6'd62};
        if (c == CHAR_SLASH) r = {1'b0, 6'd63};
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/ewtd_front.sv]
`default_nettype none

module ewtd_front
    import ewtd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       i_accept,
    input  wire t_in_word   i_word,
    output t_job            o_job,
    output logic            o_push
);

    logic [1:0]  r_mode;
    t_esc_phase  r_esc, n_esc;
    logic [3:0]  r_hi, n_hi;
    logic [1:0]  r_cnt, n_cnt;
    logic [23:0] r_acc, n_acc;
    logic [1:0]  r_pad, n_pad;
    logic        r_err, n_err;

    logic [6:0]  c;
    logic [4:0]  hexv;
    logic [6:0]  sxv;
    logic [5:0]  sx;
    logic        shift;
    logic [23:0] acc_sh;
    t_job        job;

    assign c    = i_word.text_char;
    assign hexv = hex_decode(c);
    assign sxv  = sextet_decode(c);

    always_comb begin
        n_esc = r_esc;
        n_hi  = r_hi;
        n_cnt = r_cnt;
        n_acc = r_acc;
        n_pad = r_pad;
        n_err = r_err;
        job   = '0;
        sx    = sxv[5:0];
        shift = 1'b0;
        case (r_mode)
            MODE_Q: begin
                if (r_esc != ESC_IDLE) begin
                    if (hexv[4]) begin
                        n_err = 1'b1;
                        n_esc = ESC_IDLE;
                    end else if (r_esc == ESC_EQ) begin
                        n_hi  = hexv[3:0];
                        n_esc = ESC_HEX;
                    end else begin
                        job.bytes[0] = {r_hi, hexv[3:0]};
                        job.n_bytes  = 2'd1;
                        n_esc        = ESC_IDLE;
                    end
                end else if (c == CHAR_EQ) begin
                    n_esc = ESC_EQ;
                end else begin
                    job.bytes[0] = {1'b0, (c == CHAR_UNDER) ? CHAR_SPACE : c};
                    job.n_bytes  = 2'd1;
                end
            end
            MODE_B: begin
                if (c == CHAR_EQ) begin
                    if (r_cnt < 2'd2) begin
                        n_err = 1'b1;
                    end else begin
                        n_pad = r_pad + 2'd1;
                        sx    = '0;
                        shift = 1'b1;
                    end
                end else if (sxv[6] || r_pad != 2'd0) begin
                    n_err = 1'b1;
                end else begin
                    shift = 1'b1;
                end
            end
            default: begin
                job.bytes[0] = {1'b0, c};
                job.n_bytes  = 2'd1;
            end
        endcase

        acc_sh = {r_acc[17:0], sx};
        if (shift) begin
            if (r_cnt < 2'd3) begin
                n_cnt = r_cnt + 2'd1;
                n_acc = acc_sh;
            end else begin
                job.bytes[0] = acc_sh[23:16];
                job.bytes[1] = acc_sh[15:8];
                job.bytes[2] = acc_sh[7:0];
                job.n_bytes  = (n_pad == 2'd0) ? 2'd3 : (n_pad == 2'd1) ? 2'd2 : 2'd1;
                n_cnt        = '0;
                n_acc        = '0;
                n_pad        = '0;
            end
        end

        if (i_word.final_char) begin
            if (r_mode == MODE_Q && n_esc != ESC_IDLE) n_err = 1'b1;
            if (r_mode == MODE_B && (n_cnt != 2'd0 || n_pad != 2'd0)) n_err = 1'b1;
        end
        job.fin = i_word.final_char;
        job.err = n_err;

        if (i_word.final_char) begin
            n_esc = ESC_IDLE;
            n_hi  = '0;
            n_cnt = '0;
            n_acc = '0;
            n_pad = '0;
            n_err = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_esc <= ESC_IDLE;
            r_hi  <= '0;
            r_cnt <= '0;
            r_acc <= '0;
            r_pad <= '0;
            r_err <= 1'b0;
        end else if (i_accept) begin
            r_esc <= n_esc;
            r_hi  <= n_hi;
            r_cnt <= n_cnt;
            r_acc <= n_acc;
            r_pad <= n_pad;
            r_err <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_Q;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.n_bytes != 2'd0 || job.fin);

endmodule

`default_nettype wire

[rtl/ewtd_fifo.sv]
`default_nettype none

module ewtd_fifo
    import ewtd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_job      o_head
);

    t_job                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_AW:0]     r_count;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[FIFO_AW-1:0] == FIFO_AW'(r_wr_ptr - r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

[rtl/ewtd_back.sv]
`default_nettype none

module ewtd_back
    import ewtd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_empty,
    input  wire t_job  i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_out_word  o_out_word
);

    logic [1:0] r_k;
    logic [1:0] total;
    logic       last;
    logic       hit;
    logic [7:0] sel;

    assign total = (i_head.n_bytes == 2'd0) ? 2'd1 : i_head.n_bytes;
    assign last  = (r_k == total - 2'd1);
    assign hit   = (r_k < i_head.n_bytes);

    always_comb begin
        case (r_k)
            2'd0:    sel = i_head.bytes[0];
            2'd1:    sel = i_head.bytes[1];
            2'd2:    sel = i_head.bytes[2];
            default: sel = '0;
        endcase
    end

    assign o_out_valid             = !i_empty;
    assign o_out_word.data_byte    = hit ? sel : 8'd0;
    assign o_out_word.byte_valid   = hit;
    assign o_out_word.end_of_text  = i_head.fin && last;
    assign o_out_word.decode_error = i_head.err;
    assign o_pop                   = o_out_valid && i_out_ready && last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (o_out_valid && i_out_ready) begin
            r_k <= last ? 2'd0 : r_k + 2'd1;
        end
    end

`ifndef SYNTHESIS
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k != 2'd3)
        else $error("byte index out of range");
    a_k_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> r_k == 2'd0)
        else $error("byte index left open on empty queue");
    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.end_of_text) |-> last)
        else $error("end of text before last byte");
`endif

endmodule

`default_nettype wire

[rtl/encoded_word_text_decoder_core.sv]
// channel   dir  handshake                  word
// config    in   i_cfg_we                   i_cfg_data (mode)
// text      in   i_in_valid / o_in_ready    i_in_word  (t_in_word)
// bytes     out  o_out_valid / i_out_ready  o_out_word (t_out_word)
//
// One character accepted per cycle while the result queue has room.
// Bytes leave at one per cycle from the queue head while i_out_ready is high; a base64 group gives up to three.
// Each accepted character's results are registered in the result queue before they reach the output.
// Synchronous active-low reset clears decode state, mode (to Q) and the queue.
// Output stalls fill the four-entry queue, then o_in_ready drops.
`default_nettype none

module encoded_word_text_decoder_core
    import ewtd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_word   i_in_word,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_word       o_out_word
);

    t_job job;
    t_job head;
    logic push;
    logic pop;
    logic full;
    logic empty;

    assign o_in_ready = !full;

    ewtd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (i_in_valid && o_in_ready),
        .i_word     (i_in_word),
        .o_job      (job),
        .o_push     (push)
    );

    ewtd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    ewtd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

[verif/ewtd_byte_checker.sv]
`default_nettype none

module ewtd_byte_checker
    import ewtd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_ready,
    input  wire t_in_word   i_in_word,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_ready,
    input  wire t_out_word  i_out_word,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [1:0]  mode;
    t_esc_phase  esc;
    logic [3:0]  hi_nib;
    logic [1:0]  sext_cnt;
    logic [23:0] sext_acc;
    logic [1:0]  pad_cnt;
    logic        err_flag;
    t_out_word   expected_bytes[$];
    int          fails = 0;

    function automatic void clear_decode();
        esc      = ESC_IDLE;
        hi_nib   = '0;
        sext_cnt = '0;
        sext_acc = '0;
        pad_cnt  = '0;
        err_flag = 1'b0;
    endfunction

    function automatic int hex_value_of(input logic [6:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic int sextet_value_of(input logic [6:0] c);
        if (c >= "A" && c <= "Z") return int'(c) - int'("A");
        if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
        if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
        if (c == CHAR_PLUS) return 62;
        if (c == CHAR_SLASH) return 63;
        return -1;
    endfunction

    // works out the byte words one character gives and queues them
    task automatic decode_char(input logic [6:0] c, input logic fin);
        logic [7:0] got [3];
        int         n;
        int         count;
        int         v;
        bit         take;
        t_out_word  w;
        got = '{8'h00, 8'h00, 8'h00};
        n = 0;
        case (mode)
            MODE_Q: begin
                if (esc != ESC_IDLE) begin
                    v = hex_value_of(c);
                    if (v < 0) begin
                        err_flag = 1'b1;
                        esc = ESC_IDLE;
                    end else if (esc == ESC_EQ) begin
                        hi_nib = v[3:0];
                        esc = ESC_HEX;
                    end else begin
                        esc = ESC_IDLE;
                        got[0] = {hi_nib, v[3:0]};
                        n = 1;
                    end
                end else if (c == CHAR_EQ) begin
                    esc = ESC_EQ;
                end else begin
                    got[0] = {1'b0, (c == CHAR_UNDER) ? CHAR_SPACE : c};
                    n = 1;
                end
            end
            MODE_B: begin
                take = 1'b1;
                v = 0;
                if (c == CHAR_EQ) begin
                    if (sext_cnt < 2) begin
                        err_flag = 1'b1;
                        take = 1'b0;
                    end else begin
                        pad_cnt = pad_cnt + 2'd1;
                    end
                end else begin
                    v = sextet_value_of(c);
                    if (v < 0 || pad_cnt != 0) begin
                        err_flag = 1'b1;
                        take = 1'b0;
                    end
                end
                if (take) begin
                    sext_acc = {sext_acc[17:0], v[5:0]};
                    if (sext_cnt != 2'd3) begin
                        sext_cnt = sext_cnt + 2'd1;
                    end else begin
                        n = 3 - int'(pad_cnt);
                        if (n < 1) n = 1;
                        got[0] = sext_acc[23:16];
                        got[1] = sext_acc[15:8];
                        got[2] = sext_acc[7:0];
                        sext_cnt = '0;
                        sext_acc = '0;
                        pad_cnt  = '0;
                    end
                end
            end
            default: begin
                got[0] = {1'b0, c};
                n = 1;
            end
        endcase
        if (fin) begin
            if (mode == MODE_Q && esc != ESC_IDLE) err_flag = 1'b1;
            if (mode == MODE_B && (sext_cnt != 0 || pad_cnt != 0)) err_flag = 1'b1;
        end
        count = (fin && n == 0) ? 1 : n;
        for (int k = 0; k < count; k++) begin
            w.data_byte    = (k < n) ? got[k] : 8'h00;
            w.byte_valid   = (k < n);
            w.end_of_text  = fin && (k == count - 1);
            w.decode_error = err_flag;
            expected_bytes.insert(expected_bytes.size(), w);
        end
        if (fin) clear_decode();
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            mode = MODE_Q;
            clear_decode();
            expected_bytes.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected byte word %h/%b/%b/%b",
                                 i_out_word.data_byte, i_out_word.byte_valid,
                                 i_out_word.end_of_text, i_out_word.decode_error);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (i_out_word !== want) begin
                        if (fails < 10)
                            $display("byte word mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                                     want.data_byte, want.byte_valid,
                                     want.end_of_text, want.decode_error,
                                     i_out_word.data_byte, i_out_word.byte_valid,
                                     i_out_word.end_of_text, i_out_word.decode_error);
                        fails++;
                    end
                end
            end
            if (i_cfg_we) begin
                mode = i_cfg_data;
                clear_decode();
            end
            if (i_in_valid && i_in_ready)
                decode_char(i_in_word.text_char, i_in_word.final_char);
        end
        o_fail_count <= fails;
        o_pending    <= expected_bytes.size();
    end

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ewtd_pkg::*;

    localparam logic [1:0] MODE_PASS     = 2'd2;
    localparam logic [1:0] MODE_PASS_ALT = 2'd3;
    localparam int         RANDOM_CHARS  = 350;
    localparam int         QUIET_TAIL    = 60;
    localparam string      B64_ALPHABET  =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    t_in_word   in_word;
    logic       out_valid;
    logic       out_ready;
    t_out_word  out_word;
    int         fail_count;
    int         pending;
    bit         idling_on = 1'b1;
    int         chars_sent = 0;
    logic [6:0] text_buf[$];

    encoded_word_text_decoder_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word)
    );

    ewtd_byte_checker byte_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // receiver stalls
    initial begin
        forever begin
            if (idling_on && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    function automatic logic [6:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 10) return 7'("0") + 7'(v);
        return (upper ? 7'("A") : 7'("a")) + 7'(v - 4'd10);
    endfunction

    function automatic logic [6:0] b64_char(input int idx);
        return 7'(B64_ALPHABET[idx]);
    endfunction

    function automatic void append_char(input logic [6:0] c);
        text_buf.insert(text_buf.size(), c);
    endfunction

    task automatic send_char(input logic [6:0] c, input logic fin);
        if (idling_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{text_char: c, final_char: fin};
        do @(posedge clk); while (!in_ready);
        chars_sent++;
    endtask

    task automatic send_buf(input bit closing);
        int last;
        last = text_buf.size() - 1;
        for (int i = 0; i <= last; i++) send_char(text_buf[i], closing && i == last);
        text_buf.delete();
    endtask

    task automatic send_string(input string s, input bit closing);
        for (int i = 0; i < s.len(); i++) append_char(7'(s[i]));
        send_buf(closing);
    endtask

    // hold the sender until every expected word is back and the core has settled
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        drain();
        cfg_we   <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic make_q_text();
        int         tokens;
        logic [7:0] b;
        tokens = $urandom_range(1, 8);
        repeat (tokens) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    b = 8'($urandom_range(0, 255));
                    append_char(CHAR_EQ);
                    append_char(hex_char(b[7:4], 1'($urandom_range(0, 1))));
                    append_char(hex_char(b[3:0], 1'($urandom_range(0, 1))));
                end
                4: append_char(CHAR_UNDER);
                5, 6, 7, 8: append_char(7'($urandom_range(32, 126)));
                default: begin
                    append_char(CHAR_EQ);
                    append_char(7'($urandom_range(0, 127)));
                end
            endcase
        end
        if ($urandom_range(0, 5) == 0) append_char(CHAR_EQ);
    endtask

    task automatic make_b_text();
        int groups;
        int pads;
        groups = $urandom_range(1, 4);
        repeat (4 * groups) append_char(b64_char($urandom_range(0, 63)));
        if ($urandom_range(0, 1) == 1) begin
            pads = $urandom_range(1, 2);
            for (int i = 1; i <= pads; i++) text_buf[text_buf.size() - i] = CHAR_EQ;
        end
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
                0: text_buf.insert($urandom_range(0, text_buf.size()),
                                   7'($urandom_range(0, 127)));
                1: void'(text_buf.pop_back());
                default: text_buf.insert($urandom_range(0, text_buf.size()), CHAR_EQ);
            endcase
        end
    endtask

    task automatic make_pass_text();
        repeat ($urandom_range(1, 8)) append_char(7'($urandom_range(0, 127)));
    endtask

    initial begin
        int         phase;
        int         phase_len;
        int         phase_start;
        int         stop_at;
        logic [1:0] m;
        in_valid <= 1'b0;
        in_word  <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= MODE_Q;
        rst_n    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n    <= 1'b1;

        // Q: both hex cases, underscore, extreme characters, bad first and second digit
        send_string("=3D=af_", 1'b0);
        send_char(7'h7f, 1'b0);
        send_char(7'h00, 1'b0);
        send_string("=G=4x", 1'b1);
        // B: misplaced pad, bad character, one pad, two pads
        write_mode(MODE_B);
        send_string("=*+/9=TQ==", 1'b1);
        write_mode(MODE_PASS_ALT);
        send_char(CHAR_EQ, 1'b1);

        stop_at = chars_sent + RANDOM_CHARS;
        phase = 0;
        while (chars_sent < stop_at) begin
            case (phase)
                0: m = MODE_Q;
                1: m = MODE_B;
                2: m = MODE_PASS;
                3: m = MODE_PASS_ALT;
                default: m = 2'($urandom_range(0, 3));
            endcase
            phase++;
            write_mode(m);
            phase_len = $urandom_range(20, 60);
            phase_start = chars_sent;
            while (chars_sent - phase_start < phase_len && chars_sent < stop_at) begin
                case (m)
                    MODE_Q: make_q_text();
                    MODE_B: make_b_text();
                    default: make_pass_text();
                endcase
                send_buf($urandom_range(0, 9) != 0);
                if ($urandom_range(0, 15) == 0) drain();
                if (chars_sent > stop_at - QUIET_TAIL) idling_on = 1'b0;
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
